/* src/hsvrgb_pkg.sv */
`default_nettype none

package hsvrgb_pkg;

    // Hue in 1/64 degree: one full turn and one 60-degree sector.
    localparam int unsigned HUE_FULL_TURN = 23040;
    localparam int unsigned HUE_SECTOR    = 3840;

    // Division by 15 done as a multiply by ceil(2^24 / 15) and a shift of 24.
    localparam int unsigned RECIP15_SHIFT = 24;
    localparam logic [20:0] RECIP15       = 21'd1118482;

    // Register stages from input transfer to the output register.
    localparam int unsigned NUM_STAGES = 5;

    // Sector codes, one for each 60 degrees of hue.
    localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
    localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
    localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
    localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
    localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;
    localparam logic [2:0] SEC_MAGENTA_RED   = 3'd5;

    typedef struct packed {
        logic signed [15:0] hue;
        logic [7:0]         saturation;
        logic [7:0]         brightness;
        logic [7:0]         alpha_in;
    } t_hsv_pixel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_out;
    } t_rgba_pixel;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    // Result of the front stages: chroma, value, sector and hue ramp.
    typedef struct packed {
        logic [16:0] c16;
        logic [16:0] val16;
        logic [2:0]  sector;
        logic [11:0] ramp;
        logic [7:0]  alpha;
    } t_front;

    // Result of the ramp stages: chroma, secondary component and offset.
    typedef struct packed {
        logic [16:0] c16;
        logic [16:0] x16;
        logic [16:0] m16;
        logic [2:0]  sector;
        logic [7:0]  alpha;
    } t_ramp;

endpackage

`default_nettype wire

/* src/hsvrgb_ctrl.sv */
`default_nettype none

module hsvrgb_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_ready,
    output logic                       o_ready,
    output logic                       o_valid,
    output hsvrgb_pkg::t_pipe_ctl      o_ctl
);

    localparam int unsigned N = hsvrgb_pkg::NUM_STAGES;

    logic [N-1:0] r_vld;
    logic [N-1:0] n_vld;
    logic [N-1:0] en;

    // A stage may load when it is empty or when the stage after it loads,
    // so bubbles close up even while the output is stalled.
    always_comb begin
        en[N-1] = ~r_vld[N-1] | i_ready;
        for (int k = N - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < N; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready  = en[0];
    assign o_valid  = r_vld[N-1];
    assign o_ctl.en = en;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transfer did not enter the first stage");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_vld == '1) && !i_ready) |-> !o_ready)
        else $error("full stalled pipeline still takes input");

    a_inner_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[N-2] && !en[N-1]) |=> r_vld[N-2])
        else $error("stalled item dropped from the last inner stage");

endmodule

`default_nettype wire

/* src/hsvrgb_front.sv */
`default_nettype none

module hsvrgb_front (
    input  wire logic                   i_clk,
    input  wire hsvrgb_pkg::t_pipe_ctl  i_ctl,
    input  wire hsvrgb_pkg::t_hsv_pixel i_pixel,
    output hsvrgb_pkg::t_front          o_front
);

    localparam logic signed [16:0] TURN     = 17'(hsvrgb_pkg::HUE_FULL_TURN);
    localparam logic signed [16:0] TWO_TURN = 17'(2 * hsvrgb_pkg::HUE_FULL_TURN);
    localparam logic [14:0] SEC1 = 15'(hsvrgb_pkg::HUE_SECTOR);
    localparam logic [14:0] SEC2 = 15'(2 * hsvrgb_pkg::HUE_SECTOR);
    localparam logic [14:0] SEC3 = 15'(3 * hsvrgb_pkg::HUE_SECTOR);
    localparam logic [14:0] SEC4 = 15'(4 * hsvrgb_pkg::HUE_SECTOR);
    localparam logic [14:0] SEC5 = 15'(5 * hsvrgb_pkg::HUE_SECTOR);

    // A byte scaled so that 255 is exactly 1.0 with 16 fraction bits:
    // ceil(b * 65536 / 255) = b * 257 + (b != 0).
    function automatic logic [16:0] byte_to_q16(input logic [7:0] b);
        return {1'b0, b, b} + 17'(b != 8'd0);
    endfunction

    logic signed [16:0] hue_ext;
    logic signed [16:0] hue_wrap;
    logic [16:0]        n_s0_sat;
    logic [16:0]        n_s0_val;

    logic [14:0] r_s0_hue;
    logic [16:0] r_s0_sat;
    logic [16:0] r_s0_val;
    logic [7:0]  r_s0_alpha;

    always_comb begin
        hue_ext = {i_pixel.hue[15], i_pixel.hue};
        if (hue_ext < -TURN) begin
            hue_wrap = hue_ext + TWO_TURN;
        end else if (hue_ext < 17'sd0) begin
            hue_wrap = hue_ext + TURN;
        end else if (hue_ext >= TURN) begin
            hue_wrap = hue_ext - TURN;
        end else begin
            hue_wrap = hue_ext;
        end
        n_s0_sat = byte_to_q16(i_pixel.saturation);
        n_s0_val = byte_to_q16(i_pixel.brightness);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_s0_hue   <= hue_wrap[14:0];
            r_s0_sat   <= n_s0_sat;
            r_s0_val   <= n_s0_val;
            r_s0_alpha <= i_pixel.alpha_in;
        end
    end

    logic [33:0]        prod_vs;
    logic [2:0]         sector;
    logic [14:0]        pair_base;
    logic [12:0]        pos;
    logic signed [13:0] dist_signed;
    logic [11:0]        dist_abs;

    // Sector from the wrapped hue; pos is the hue modulo two sectors, and
    // the ramp rises over even sectors and falls over odd ones.
    always_comb begin
        prod_vs = r_s0_val * r_s0_sat;
        if (r_s0_hue >= SEC5) begin
            sector = hsvrgb_pkg::SEC_MAGENTA_RED;
        end else if (r_s0_hue >= SEC4) begin
            sector = hsvrgb_pkg::SEC_BLUE_MAGENTA;
        end else if (r_s0_hue >= SEC3) begin
            sector = hsvrgb_pkg::SEC_CYAN_BLUE;
        end else if (r_s0_hue >= SEC2) begin
            sector = hsvrgb_pkg::SEC_GREEN_CYAN;
        end else if (r_s0_hue >= SEC1) begin
            sector = hsvrgb_pkg::SEC_YELLOW_GREEN;
        end else begin
            sector = hsvrgb_pkg::SEC_RED_YELLOW;
        end
        if (r_s0_hue >= SEC4) begin
            pair_base = SEC4;
        end else if (r_s0_hue >= SEC2) begin
            pair_base = SEC2;
        end else begin
            pair_base = '0;
        end
        pos  = 13'(r_s0_hue - pair_base);
        dist_signed = $signed({1'b0, pos}) - $signed({2'b00, SEC1[11:0]});
        dist_abs = dist_signed[13] ? 12'(-dist_signed) : dist_signed[11:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            o_front.c16    <= prod_vs[32:16];
            o_front.val16  <= r_s0_val;
            o_front.sector <= sector;
            o_front.ramp   <= SEC1[11:0] - dist_abs;
            o_front.alpha  <= r_s0_alpha;
        end
    end

endmodule

`default_nettype wire

/* src/hsvrgb_ramp.sv */
`default_nettype none

module hsvrgb_ramp (
    input  wire logic                  i_clk,
    input  wire hsvrgb_pkg::t_pipe_ctl i_ctl,
    input  wire hsvrgb_pkg::t_front    i_front,
    output hsvrgb_pkg::t_ramp          o_ramp
);

    logic [28:0] prod_cr;

    logic [19:0] r_s2_num;
    logic [16:0] r_s2_c16;
    logic [16:0] r_s2_m16;
    logic [2:0]  r_s2_sector;
    logic [7:0]  r_s2_alpha;

    // c * ramp / 3840 is split as (c * ramp / 256) / 15; the first part is
    // a shift here, the second a reciprocal multiply in the next stage.
    assign prod_cr = i_front.c16 * i_front.ramp;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_s2_num    <= prod_cr[27:8];
            r_s2_c16    <= i_front.c16;
            r_s2_m16    <= i_front.val16 - i_front.c16;
            r_s2_sector <= i_front.sector;
            r_s2_alpha  <= i_front.alpha;
        end
    end

    logic [40:0] prod_recip;

    // Exact for every numerator below 2^20, which covers the full range.
    assign prod_recip = r_s2_num * hsvrgb_pkg::RECIP15;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            o_ramp.x16    <= prod_recip[hsvrgb_pkg::RECIP15_SHIFT +: 17];
            o_ramp.c16    <= r_s2_c16;
            o_ramp.m16    <= r_s2_m16;
            o_ramp.sector <= r_s2_sector;
            o_ramp.alpha  <= r_s2_alpha;
        end
    end

endmodule

`default_nettype wire

/* src/hsvrgb_mix.sv */
`default_nettype none

module hsvrgb_mix (
    input  wire logic                  i_clk,
    input  wire hsvrgb_pkg::t_pipe_ctl i_ctl,
    input  wire hsvrgb_pkg::t_ramp     i_ramp,
    output hsvrgb_pkg::t_rgba_pixel    o_pixel
);

    // Channel plus offset never exceeds 1.0, so (q * 255) >> 16 fits a byte.
    function automatic logic [7:0] q16_to_byte(input logic [16:0] q);
        logic [24:0] scaled;
        scaled = {q, 8'd0} - {8'd0, q};
        return scaled[23:16];
    endfunction

    logic [16:0] r_lin;
    logic [16:0] g_lin;
    logic [16:0] b_lin;

    always_comb begin
        r_lin = '0;
        g_lin = '0;
        b_lin = '0;
        case (i_ramp.sector)
            hsvrgb_pkg::SEC_RED_YELLOW: begin
                r_lin = i_ramp.c16;
                g_lin = i_ramp.x16;
            end
            hsvrgb_pkg::SEC_YELLOW_GREEN: begin
                r_lin = i_ramp.x16;
                g_lin = i_ramp.c16;
            end
            hsvrgb_pkg::SEC_GREEN_CYAN: begin
                g_lin = i_ramp.c16;
                b_lin = i_ramp.x16;
            end
            hsvrgb_pkg::SEC_CYAN_BLUE: begin
                g_lin = i_ramp.x16;
                b_lin = i_ramp.c16;
            end
            hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
                r_lin = i_ramp.x16;
                b_lin = i_ramp.c16;
            end
            default: begin
                r_lin = i_ramp.c16;
                b_lin = i_ramp.x16;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            o_pixel.red       <= q16_to_byte(r_lin + i_ramp.m16);
            o_pixel.green     <= q16_to_byte(g_lin + i_ramp.m16);
            o_pixel.blue      <= q16_to_byte(b_lin + i_ramp.m16);
            o_pixel.alpha_out <= i_ramp.alpha;
        end
    end

endmodule

`default_nettype wire

/* src/hsv_to_rgb_pixel_converter.sv */
// Path: a pixel transferred in is registered in stage 0, then in the front, numerator, ramp and output registers.
// Throughput: one pixel per clock cycle while the output is not stalled, set by the five-stage pipeline with no loop.
// Each stage refills as soon as it empties, so a stall at the output holds every pixel.
// Reset (synchronous, active low) clears the stage valid bits only; data registers are kept.
`default_nettype none

module hsv_to_rgb_pixel_converter (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire hsvrgb_pkg::t_hsv_pixel  i_pixel,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output hsvrgb_pkg::t_rgba_pixel      o_pixel
);

    hsvrgb_pkg::t_pipe_ctl ctl;
    hsvrgb_pkg::t_front    front;
    hsvrgb_pkg::t_ramp     ramp;

    hsvrgb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_ctl   (ctl)
    );

    hsvrgb_front u_front (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_pixel (i_pixel),
        .o_front (front)
    );

    hsvrgb_ramp u_ramp (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_front (front),
        .o_ramp  (ramp)
    );

    hsvrgb_mix u_mix (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_ramp  (ramp),
        .o_pixel (o_pixel)
    );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int TURN_UNITS     = int'(hsvrgb_pkg::HUE_FULL_TURN);
    localparam int SECTOR_UNITS   = int'(hsvrgb_pkg::HUE_SECTOR);
    localparam int RANDOM_PIXELS  = 650;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    hsvrgb_pkg::t_hsv_pixel  i_pixel;
    logic                    o_valid;
    logic                    i_ready;
    hsvrgb_pkg::t_rgba_pixel o_pixel;

    class rgba_scoreboard;
        hsvrgb_pkg::t_rgba_pixel pending_rgba[$];
        int unsigned errors;

        function int unsigned byte_to_q16(logic [7:0] b);
            return (int'(b) * 65536 + 254) / 255;
        endfunction

        function logic [7:0] q16_to_channel(int unsigned q);
            longint scaled;
            scaled = (longint'(q) * 255) >>> 16;
            return (scaled > 255) ? 8'd255 : scaled[7:0];
        endfunction

        function hsvrgb_pkg::t_rgba_pixel hsv_to_rgba(hsvrgb_pkg::t_hsv_pixel px);
            int          hue_wrapped;
            int          ramp_pos;
            int          hue_dist;
            int unsigned sat16;
            int unsigned val16;
            int unsigned c16;
            int unsigned m16;
            int unsigned x16;
            int unsigned red16;
            int unsigned green16;
            int unsigned blue16;
            logic [2:0]  sector;
            hsvrgb_pkg::t_rgba_pixel res;
            hue_wrapped = $signed(px.hue);
            hue_wrapped = hue_wrapped % TURN_UNITS;
            if (hue_wrapped < 0) begin
                hue_wrapped = hue_wrapped + TURN_UNITS;
            end
            sat16 = byte_to_q16(px.saturation);
            val16 = byte_to_q16(px.brightness);
            c16 = 32'((longint'(val16) * longint'(sat16)) >>> 16);
            m16 = val16 - c16;
            // The secondary component rises and falls over each pair of sectors.
            ramp_pos = hue_wrapped % (2 * SECTOR_UNITS);
            hue_dist = ramp_pos - SECTOR_UNITS;
            if (hue_dist < 0) begin
                hue_dist = -hue_dist;
            end
            x16 = 32'((longint'(c16) * longint'(SECTOR_UNITS - hue_dist))
                      / longint'(SECTOR_UNITS));
            sector = 3'(hue_wrapped / SECTOR_UNITS);
            red16 = 0;
            green16 = 0;
            blue16 = 0;
            case (sector)
                hsvrgb_pkg::SEC_RED_YELLOW: begin
                    red16 = c16;
                    green16 = x16;
                end
                hsvrgb_pkg::SEC_YELLOW_GREEN: begin
                    red16 = x16;
                    green16 = c16;
                end
                hsvrgb_pkg::SEC_GREEN_CYAN: begin
                    green16 = c16;
                    blue16 = x16;
                end
                hsvrgb_pkg::SEC_CYAN_BLUE: begin
                    green16 = x16;
                    blue16 = c16;
                end
                hsvrgb_pkg::SEC_BLUE_MAGENTA: begin
                    red16 = x16;
                    blue16 = c16;
                end
                default: begin
                    red16 = c16;
                    blue16 = x16;
                end
            endcase
            res.red = q16_to_channel(red16 + m16);
            res.green = q16_to_channel(green16 + m16);
            res.blue = q16_to_channel(blue16 + m16);
            res.alpha_out = px.alpha_in;
            return res;
        endfunction

        function void note_hsv(hsvrgb_pkg::t_hsv_pixel px);
            pending_rgba.push_back(hsv_to_rgba(px));
        endfunction

        function void check_rgba(hsvrgb_pkg::t_rgba_pixel got);
            hsvrgb_pkg::t_rgba_pixel want;
            if (pending_rgba.size() == 0) begin
                $error("result pixel %h arrived with none expected", got);
                errors++;
                return;
            end
            want = pending_rgba.pop_front();
            if (got.red !== want.red) begin
                $error("red: expected %0d, actual %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green) begin
                $error("green: expected %0d, actual %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue) begin
                $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                errors++;
            end
            if (got.alpha_out !== want.alpha_out) begin
                $error("alpha_out: expected %0d, actual %0d", want.alpha_out, got.alpha_out);
                errors++;
            end
        endfunction
    endclass

    rgba_scoreboard sb = new();

    hsv_to_rgb_pixel_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pixel (o_pixel)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no idle cycles, sometimes a few, rarely a long stretch.
    function automatic int unsigned idle_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end else if (pick < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 99) < 12) begin
            return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_hue();
        int near;
        if ($urandom_range(0, 2) == 0) begin
            // Close to a sector edge, including whole turns and negative angles.
            near = (int'($urandom_range(0, 16)) - 8) * SECTOR_UNITS
                   + int'($urandom_range(0, 4)) - 2;
            return 16'(near);
        end
        return 16'($urandom);
    endfunction

    function automatic hsvrgb_pkg::t_hsv_pixel make_hsv(int hue, int sat, int val, int alpha);
        hsvrgb_pkg::t_hsv_pixel px;
        px.hue = 16'(hue);
        px.saturation = 8'(sat);
        px.brightness = 8'(val);
        px.alpha_in = 8'(alpha);
        return px;
    endfunction

    // Offers one pixel after an optional gap; with drain set, the gap lasts until
    // every expected result has come back.
    task automatic send_hsv(hsvrgb_pkg::t_hsv_pixel px, int unsigned gap, bit drain);
        if (gap > 0 || drain) begin
            i_valid <= 1'b0;
            repeat ((gap == 0) ? 1 : gap) @(posedge i_clk);
            while (drain && sb.pending_rgba.size() != 0) begin
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sb.note_hsv(px);
    endtask

    // Result side: random stalls, stretches of steady readiness, and two long holds.
    initial begin
        int unsigned seen;
        int unsigned stall_left;
        int unsigned block_left;
        int unsigned long_holds;
        bit          steady;
        bit          ready_now;
        seen = 0;
        stall_left = 0;
        block_left = 0;
        long_holds = 0;
        steady = 1'b0;
        i_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (block_left == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                block_left = 50;
            end
            block_left--;
            if (stall_left == 0) begin
                if (long_holds < 2 && seen >= ((long_holds == 0) ? 100 : 450)) begin
                    stall_left = LONG_HOLD;
                    long_holds++;
                end else if (!steady) begin
                    stall_left = idle_len();
                end
            end
            ready_now = (stall_left == 0);
            if (stall_left > 0) begin
                stall_left--;
            end
            i_ready <= ready_now;
            @(posedge i_clk);
            if (i_ready && o_valid) begin
                sb.check_rgba(o_pixel);
                seen++;
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        hsvrgb_pkg::t_hsv_pixel directed[$];
        bit                     steady;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_pixel <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pure hues on every sector edge, then the wrap cases and grey or black pixels.
        directed.push_back(make_hsv(0, 255, 255, 255));
        directed.push_back(make_hsv(3840, 255, 255, 0));
        directed.push_back(make_hsv(7680, 255, 255, 128));
        directed.push_back(make_hsv(11520, 255, 255, 1));
        directed.push_back(make_hsv(15360, 255, 255, 254));
        directed.push_back(make_hsv(19200, 255, 255, 255));
        directed.push_back(make_hsv(1920, 255, 255, 17));
        directed.push_back(make_hsv(3839, 255, 255, 33));
        directed.push_back(make_hsv(23039, 255, 255, 66));
        directed.push_back(make_hsv(23040, 255, 255, 99));
        directed.push_back(make_hsv(-1, 255, 255, 170));
        directed.push_back(make_hsv(-23040, 255, 255, 85));
        directed.push_back(make_hsv(32767, 200, 100, 7));
        directed.push_back(make_hsv(-32768, 100, 200, 8));
        directed.push_back(make_hsv(5000, 0, 200, 9));
        directed.push_back(make_hsv(-9000, 0, 255, 10));
        directed.push_back(make_hsv(12000, 255, 0, 11));
        directed.push_back(make_hsv(17000, 0, 0, 12));
        directed.push_back(make_hsv(9000, 1, 1, 13));
        directed.push_back(make_hsv(21000, 128, 77, 14));
        directed.push_back(make_hsv(-15360, 255, 128, 15));
        directed.push_back(make_hsv(30000, 254, 254, 16));
        directed.push_back(make_hsv(13440, 127, 128, 240));
        foreach (directed[k]) begin
            send_hsv(directed[k], idle_len(), 1'b0);
        end

        steady = 1'b0;
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n % 40 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            send_hsv(make_hsv(int'(rand_hue()), rand_byte(), rand_byte(), rand_byte()),
                     steady ? 0 : idle_len(), n == 250);
        end

        i_valid <= 1'b0;
        while (sb.pending_rgba.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (hsvrgb_pkg::NUM_STAGES + 4) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_rgba.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
